// ===== src/cau_pkg.sv =====
package cau_pkg;

    // Operation codes carried in the op field of an input item.
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4,
        OP_ARG = 3'd5
    } t_op;

    // Number of CORDIC rotations used for the argument.
    localparam int CORDIC_ITERS = 36;

    // 180/pi in Q32.
    localparam logic [63:0] DEG_Q32 = 64'd246083499208;

    // Bitwise long division, used only while building the angle constants.
    function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in degrees, Q32, from a Q62 series for atan.
    function automatic logic [63:0] step_angle(input int i);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        int           e;
        sum = '0;
        if (i == 0) begin
            return 64'd45 << 32;
        end
        for (int k = 0; k < 64; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
                term = const_udiv(64'd1 << e, 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        prod = {64'd0, sum} * {64'd0, DEG_Q32};
        return prod[125:62];
    endfunction

endpackage

// ===== src/complex_arith_unit.sv =====
// Pipeline: unpack, products, sums, start values, the iteration stages, then the output register.
// Throughput: one item per cycle unless a finished item is blocked at the output; every unit is
// fully pipelined, at most one quotient bit, one root bit and one CORDIC rotation per stage.
// Reset: synchronous, active low; clears all valid bits, the pipeline comes up empty.
module complex_arith_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // op, a_real, a_imag, b_real, b_imag from the lowest bit up.
    input  logic [((3 + 4 * DATA_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // res_real, res_imag from the lowest bit up.
    output logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] o_m_tdata,
    // error.
    output logic                                       o_m_tuser
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int PB = $clog2(DW);
    localparam int MW = 2 * DW;
    localparam int PW = MW + 1;
    localparam int RW = PW + DW + FB;
    localparam int SW = RW;
    localparam int CI = cau_pkg::CORDIC_ITERS;
    localparam int L  = (DW > CI) ? DW : CI;
    localparam int OW = ((2 * DW + 7) / 8) * 8;

    // Signed-magnitude add; result is {sign, magnitude}.
    function automatic logic [PW:0] sm_add(input logic an, input logic [MW-1:0] am,
                                           input logic bn, input logic [MW-1:0] bm);
        logic [PW:0] r;
        if (an == bn) begin
            r = {an, PW'(am) + PW'(bm)};
        end else if (am >= bm) begin
            r = {an, PW'(am - bm)};
        end else begin
            r = {bn, PW'(bm - am)};
        end
        return r;
    endfunction

    // Saturate a signed-magnitude value to the signed output range.
    function automatic logic [DW-1:0] sat(input logic neg, input logic [SW-1:0] mag);
        logic [SW-1:0] lim;
        logic [SW-1:0] m;
        logic [DW-1:0] r;
        lim = SW'(1) << (DW - 1);
        if (!neg) begin
            r = (mag > lim - SW'(1)) ? DW'(lim - SW'(1)) : mag[DW-1:0];
        end else begin
            m = (mag > lim) ? lim : mag;
            r = DW'(SW'(0) - m);
        end
        return r;
    endfunction

    // Index of the highest set bit.
    function automatic logic [PB-1:0] msb(input logic [DW-1:0] v);
        logic [PB-1:0] p;
        p = '0;
        for (int i = 0; i < DW; i++) begin
            if (v[i]) begin
                p = PB'(i);
            end
        end
        return p;
    endfunction

    logic en;
    logic out_ld;

    // Stage 1: operand unpack.
    logic          r_s1_v;
    logic [2:0]    r_s1_op;
    logic          r_s1_arn, r_s1_ain, r_s1_brn, r_s1_bin;
    logic [DW-1:0] r_s1_ar, r_s1_ai, r_s1_br, r_s1_bi;
    logic [DW-1:0] in_ar, in_ai, in_br, in_bi;

    // Stage 2: products.
    logic          r_s2_v;
    logic [2:0]    r_s2_op;
    logic          r_s2_arn, r_s2_ain, r_s2_brn, r_s2_bin;
    logic [DW-1:0] r_s2_ar, r_s2_ai, r_s2_br, r_s2_bi;
    logic [MW-1:0] r_s2_p0, r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4, r_s2_p5;
    logic          r_s2_s0, r_s2_s1, r_s2_s2, r_s2_s3;
    logic [PB-1:0] r_s2_pos;

    // Stage 3: sums and CORDIC normalization.
    logic          r_s3_v;
    logic [2:0]    r_s3_op;
    logic [DW-1:0] r_s3_res_re, r_s3_res_im;
    logic [PW:0]   r_s3_re, r_s3_im;
    logic [PW-1:0] r_s3_d;
    logic [63:0]   r_s3_cx, r_s3_cy;
    logic          r_s3_arz, r_s3_aiz, r_s3_ain, r_s3_sgn;

    // Iteration stages.
    logic                r_it_v      [0:L];
    logic [2:0]          r_it_op     [0:L];
    logic                r_it_err    [0:L];
    logic                r_it_spec   [0:L];
    logic                r_it_sgn    [0:L];
    logic [DW-1:0]       r_it_res_re [0:L];
    logic [DW-1:0]       r_it_res_im [0:L];
    logic                r_it_neg_re [0:L];
    logic                r_it_neg_im [0:L];
    logic                r_it_ovf_re [0:L];
    logic                r_it_ovf_im [0:L];
    logic [RW-1:0]       r_it_rem_re [0:L];
    logic [RW-1:0]       r_it_rem_im [0:L];
    logic [DW-1:0]       r_it_q_re   [0:L];
    logic [DW-1:0]       r_it_q_im   [0:L];
    logic [PW-1:0]       r_it_d      [0:L];
    logic [PW-1:0]       r_it_sq     [0:L];
    logic [DW-1:0]       r_it_root   [0:L];
    logic [63:0]         r_it_cx     [0:L];
    logic [63:0]         r_it_cy     [0:L];
    logic signed [63:0]  r_it_cz     [0:L];

    // Output register.
    logic          r_out_v;
    logic [DW-1:0] r_out_re, r_out_im;
    logic          r_out_err;

    // The pipeline moves unless a finished item is blocked at the output.
    assign out_ld     = ~r_out_v | i_m_tready;
    assign en         = out_ld | ~r_it_v[L];
    assign o_s_tready = en;

    assign in_ar = i_s_tdata[3 +: DW];
    assign in_ai = i_s_tdata[3 + DW +: DW];
    assign in_br = i_s_tdata[3 + 2 * DW +: DW];
    assign in_bi = i_s_tdata[3 + 3 * DW +: DW];

    // Stage 1: split each operand into sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op  <= i_s_tdata[2:0];
            r_s1_arn <= in_ar[DW-1];
            r_s1_ain <= in_ai[DW-1];
            r_s1_brn <= in_br[DW-1];
            r_s1_bin <= in_bi[DW-1];
            r_s1_ar  <= in_ar[DW-1] ? (~in_ar + DW'(1)) : in_ar;
            r_s1_ai  <= in_ai[DW-1] ? (~in_ai + DW'(1)) : in_ai;
            r_s1_br  <= in_br[DW-1] ? (~in_br + DW'(1)) : in_br;
            r_s1_bi  <= in_bi[DW-1] ? (~in_bi + DW'(1)) : in_bi;
        end
    end

    // Stage 2: six products; the squares serve magnitude or divisor.
    logic [DW-1:0] sq_a, sq_b;
    assign sq_a = (r_s1_op == cau_pkg::OP_MAG) ? r_s1_ar : r_s1_br;
    assign sq_b = (r_s1_op == cau_pkg::OP_MAG) ? r_s1_ai : r_s1_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_op  <= r_s1_op;
            r_s2_arn <= r_s1_arn;
            r_s2_ain <= r_s1_ain;
            r_s2_brn <= r_s1_brn;
            r_s2_bin <= r_s1_bin;
            r_s2_ar  <= r_s1_ar;
            r_s2_ai  <= r_s1_ai;
            r_s2_br  <= r_s1_br;
            r_s2_bi  <= r_s1_bi;
            r_s2_p0  <= MW'(r_s1_ar) * MW'(r_s1_br);
            r_s2_p1  <= MW'(r_s1_ai) * MW'(r_s1_bi);
            r_s2_p2  <= MW'(r_s1_ar) * MW'(r_s1_bi);
            r_s2_p3  <= MW'(r_s1_ai) * MW'(r_s1_br);
            r_s2_p4  <= MW'(sq_a) * MW'(sq_a);
            r_s2_p5  <= MW'(sq_b) * MW'(sq_b);
            r_s2_s0  <= r_s1_arn ^ r_s1_brn;
            r_s2_s1  <= r_s1_ain ^ r_s1_bin;
            r_s2_s2  <= r_s1_arn ^ r_s1_bin;
            r_s2_s3  <= r_s1_ain ^ r_s1_brn;
            r_s2_pos <= msb((r_s1_ar > r_s1_ai) ? r_s1_ar : r_s1_ai);
        end
    end

    // Stage 3: signed sums, add/sub results and CORDIC operand scaling.
    logic          is_sub;
    logic [PW:0]   as_re, as_im, mul_re, mul_im, div_re, div_im;
    logic [6:0]    pos7;
    logic [63:0]   nx, ny;

    assign is_sub = (r_s2_op == cau_pkg::OP_SUB);
    assign as_re  = sm_add(r_s2_arn, MW'(r_s2_ar), r_s2_brn ^ is_sub, MW'(r_s2_br));
    assign as_im  = sm_add(r_s2_ain, MW'(r_s2_ai), r_s2_bin ^ is_sub, MW'(r_s2_bi));
    assign mul_re = sm_add(r_s2_s0, r_s2_p0, ~r_s2_s1, r_s2_p1);
    assign mul_im = sm_add(r_s2_s2, r_s2_p2, r_s2_s3, r_s2_p3);
    assign div_re = sm_add(r_s2_s0, r_s2_p0, r_s2_s1, r_s2_p1);
    assign div_im = sm_add(r_s2_s3, r_s2_p3, ~r_s2_s2, r_s2_p2);
    assign pos7   = 7'(r_s2_pos);

    // Put the larger part's top bit at bit 60.
    always_comb begin
        if (pos7 > 7'd60) begin
            nx = 64'(r_s2_ar) >> (pos7 - 7'd60);
            ny = 64'(r_s2_ai) >> (pos7 - 7'd60);
        end else begin
            nx = 64'(r_s2_ar) << (7'd60 - pos7);
            ny = 64'(r_s2_ai) << (7'd60 - pos7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_op     <= r_s2_op;
            r_s3_res_re <= sat(as_re[PW], SW'(as_re[PW-1:0]));
            r_s3_res_im <= sat(as_im[PW], SW'(as_im[PW-1:0]));
            r_s3_re     <= (r_s2_op == cau_pkg::OP_MUL) ? mul_re : div_re;
            r_s3_im     <= (r_s2_op == cau_pkg::OP_MUL) ? mul_im : div_im;
            r_s3_d      <= PW'(r_s2_p4) + PW'(r_s2_p5);
            r_s3_cx     <= nx;
            r_s3_cy     <= ny;
            r_s3_arz    <= (r_s2_ar == '0);
            r_s3_aiz    <= (r_s2_ai == '0);
            r_s3_ain    <= r_s2_ain;
            r_s3_sgn    <= r_s2_arn ^ r_s2_ain;
        end
    end

    // Stage 4: product scaling, special cases and iteration start values.
    logic [DW-1:0] st_re, st_im;
    logic          st_err;
    logic [RW-1:0] n0_re, n0_im, dtop;

    assign n0_re = RW'(r_s3_re[PW-1:0]) << FB;
    assign n0_im = RW'(r_s3_im[PW-1:0]) << FB;
    assign dtop  = RW'(r_s3_d) << DW;

    always_comb begin
        st_re  = '0;
        st_im  = '0;
        st_err = 1'b0;
        case (r_s3_op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                st_re = r_s3_res_re;
                st_im = r_s3_res_im;
            end
            cau_pkg::OP_MUL: begin
                st_re = sat(r_s3_re[PW], SW'(r_s3_re[PW-1:0] >> FB));
                st_im = sat(r_s3_im[PW], SW'(r_s3_im[PW-1:0] >> FB));
            end
            cau_pkg::OP_DIV: begin
                st_err = (r_s3_d == '0);
            end
            cau_pkg::OP_ARG: begin
                st_err = r_s3_arz & r_s3_aiz;
                // Pure imaginary operand: plus or minus 90 degrees.
                if (r_s3_arz && !r_s3_aiz) begin
                    st_re = sat(r_s3_ain, SW'(90) << FB);
                end
            end
            default: begin
                st_err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_v[0] <= 1'b0;
        end else if (en) begin
            r_it_v[0] <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it_op[0]     <= r_s3_op;
            r_it_err[0]    <= st_err;
            r_it_spec[0]   <= r_s3_arz | r_s3_aiz;
            r_it_sgn[0]    <= r_s3_sgn;
            r_it_res_re[0] <= st_re;
            r_it_res_im[0] <= st_im;
            r_it_neg_re[0] <= r_s3_re[PW];
            r_it_neg_im[0] <= r_s3_im[PW];
            r_it_ovf_re[0] <= (n0_re >= dtop);
            r_it_ovf_im[0] <= (n0_im >= dtop);
            r_it_rem_re[0] <= n0_re;
            r_it_rem_im[0] <= n0_im;
            r_it_q_re[0]   <= '0;
            r_it_q_im[0]   <= '0;
            r_it_d[0]      <= r_s3_d;
            r_it_sq[0]     <= r_s3_d;
            r_it_root[0]   <= '0;
            r_it_cx[0]     <= r_s3_cx;
            r_it_cy[0]     <= r_s3_cy;
            r_it_cz[0]     <= '0;
        end
    end

    // Iteration stages: at most one quotient bit, one root bit and one rotation each.
    for (genvar j = 0; j < L; j++) begin : g_it
        logic [RW-1:0]       n_rem_re, n_rem_im;
        logic [DW-1:0]       n_q_re, n_q_im;
        logic [PW-1:0]       n_sq;
        logic [DW-1:0]       n_root;
        logic [63:0]         n_cx, n_cy;
        logic signed [63:0]  n_cz;

        if (j < DW) begin : g_div
            localparam int K = DW - 1 - j;
            logic          ge_re, ge_im, ge_sq;
            logic [RW-1:0] dsh;
            logic [PW-1:0] trial;

            assign dsh   = RW'(r_it_d[j]) << K;
            assign trial = (PW'(r_it_root[j]) << (K + 1)) | (PW'(1) << (2 * K));

            cau_csub #(.W(RW)) u_div_re (
                .i_rem (r_it_rem_re[j]),
                .i_sub (dsh),
                .o_rem (n_rem_re),
                .o_ge  (ge_re)
            );

            cau_csub #(.W(RW)) u_div_im (
                .i_rem (r_it_rem_im[j]),
                .i_sub (dsh),
                .o_rem (n_rem_im),
                .o_ge  (ge_im)
            );

            cau_csub #(.W(PW)) u_sqrt (
                .i_rem (r_it_sq[j]),
                .i_sub (trial),
                .o_rem (n_sq),
                .o_ge  (ge_sq)
            );

            assign n_q_re = r_it_q_re[j] | (DW'(ge_re) << K);
            assign n_q_im = r_it_q_im[j] | (DW'(ge_im) << K);
            assign n_root = r_it_root[j] | (DW'(ge_sq) << K);
        end else begin : g_div_hold
            assign n_rem_re = r_it_rem_re[j];
            assign n_rem_im = r_it_rem_im[j];
            assign n_q_re   = r_it_q_re[j];
            assign n_q_im   = r_it_q_im[j];
            assign n_sq     = r_it_sq[j];
            assign n_root   = r_it_root[j];
        end

        if (j < CI) begin : g_cor
            cau_cordic_step #(.STEP(j)) u_cor (
                .i_x (r_it_cx[j]),
                .i_y (r_it_cy[j]),
                .i_z (r_it_cz[j]),
                .o_x (n_cx),
                .o_y (n_cy),
                .o_z (n_cz)
            );
        end else begin : g_cor_hold
            assign n_cx = r_it_cx[j];
            assign n_cy = r_it_cy[j];
            assign n_cz = r_it_cz[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_it_v[j+1] <= 1'b0;
            end else if (en) begin
                r_it_v[j+1] <= r_it_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_it_op[j+1]     <= r_it_op[j];
                r_it_err[j+1]    <= r_it_err[j];
                r_it_spec[j+1]   <= r_it_spec[j];
                r_it_sgn[j+1]    <= r_it_sgn[j];
                r_it_res_re[j+1] <= r_it_res_re[j];
                r_it_res_im[j+1] <= r_it_res_im[j];
                r_it_neg_re[j+1] <= r_it_neg_re[j];
                r_it_neg_im[j+1] <= r_it_neg_im[j];
                r_it_ovf_re[j+1] <= r_it_ovf_re[j];
                r_it_ovf_im[j+1] <= r_it_ovf_im[j];
                r_it_rem_re[j+1] <= n_rem_re;
                r_it_rem_im[j+1] <= n_rem_im;
                r_it_q_re[j+1]   <= n_q_re;
                r_it_q_im[j+1]   <= n_q_im;
                r_it_d[j+1]      <= r_it_d[j];
                r_it_sq[j+1]     <= n_sq;
                r_it_root[j+1]   <= n_root;
                r_it_cx[j+1]     <= n_cx;
                r_it_cy[j+1]     <= n_cy;
                r_it_cz[j+1]     <= n_cz;
            end
        end
    end

    // Final stage: pick the result by operation and saturate.
    logic [63:0]   zc;
    logic [64:0]   zq;
    logic [DW-1:0] fin_re, fin_im;

    assign zc = r_it_cz[L][63] ? 64'd0 : r_it_cz[L];
    assign zq = (65'(zc) + (65'(1) << (31 - FB))) >> (32 - FB);

    always_comb begin
        fin_re = '0;
        fin_im = '0;
        case (r_it_op[L])
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
                fin_re = r_it_res_re[L];
                fin_im = r_it_res_im[L];
            end
            cau_pkg::OP_DIV: begin
                if (!r_it_err[L]) begin
                    fin_re = sat(r_it_neg_re[L],
                                 r_it_ovf_re[L] ? {SW{1'b1}} : SW'(r_it_q_re[L]));
                    fin_im = sat(r_it_neg_im[L],
                                 r_it_ovf_im[L] ? {SW{1'b1}} : SW'(r_it_q_im[L]));
                end
            end
            cau_pkg::OP_MAG: begin
                fin_re = sat(1'b0, SW'(r_it_root[L]));
            end
            cau_pkg::OP_ARG: begin
                if (r_it_err[L] || r_it_spec[L]) begin
                    fin_re = r_it_res_re[L];
                end else begin
                    fin_re = sat(r_it_sgn[L], SW'(zq));
                end
            end
            default: begin
                fin_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ld) begin
            r_out_v <= r_it_v[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out_re  <= fin_re;
            r_out_im  <= fin_im;
            r_out_err <= r_it_err[L];
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OW'({r_out_im, r_out_re});
    assign o_m_tuser  = r_out_err;

endmodule

// ===== src/cau_csub.sv =====
// One restoring step: subtract the trial value when it fits.
module cau_csub #(
    parameter int W = 32
) (
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_sub,
    output logic [W-1:0] o_rem,
    output logic         o_ge
);

    assign o_ge  = (i_rem >= i_sub);
    assign o_rem = o_ge ? (i_rem - i_sub) : i_rem;

endmodule

// ===== src/cau_cordic_step.sv =====
// One CORDIC vectoring rotation with a fixed shift and step angle.
module cau_cordic_step #(
    parameter int STEP = 0
) (
    input  logic [63:0]        i_x,
    input  logic [63:0]        i_y,
    input  logic signed [63:0] i_z,
    output logic [63:0]        o_x,
    output logic [63:0]        o_y,
    output logic signed [63:0] o_z
);

    localparam logic [63:0] ANGLE = cau_pkg::step_angle(STEP);

    logic [63:0] xs;
    logic [63:0] ys;

    assign xs = i_x >> STEP;
    assign ys = 64'($signed(i_y) >>> STEP);

    // Rotate toward the x axis according to the sign of y.
    always_comb begin
        if (!i_y[63]) begin
            o_x = i_x + ys;
            o_y = i_y - xs;
            o_z = i_z + $signed(ANGLE);
        end else begin
            o_x = i_x - ys;
            o_y = i_y + xs;
            o_z = i_z - $signed(ANGLE);
        end
    end

endmodule

// ===== tb/complex_arith_unit_checker.sv =====
`timescale 1ns / 1ps

module complex_arith_unit_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending
);

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        err;
    } t_result;

    localparam int FRAC = 16;

    t_result     expected_q[$];
    logic [63:0] atan_deg_q32[cau_pkg::CORDIC_ITERS];

    // Step angles atan(2^-i) in degrees, Q32, from a Q62 series.
    initial begin
        logic [63:0]  sum;
        logic [127:0] prod;
        int           e;
        for (int i = 0; i < cau_pkg::CORDIC_ITERS; i++) begin
            if (i == 0) begin
                atan_deg_q32[i] = 64'd45 << 32;
            end else begin
                sum = '0;
                for (int k = 0; k < 64; k++) begin
                    e = 62 - i * (2 * k + 1);
                    if (e < 0) break;
                    if (k % 2 == 1) begin
                        sum = sum - (64'd1 << e) / 64'(2 * k + 1);
                    end else begin
                        sum = sum + (64'd1 << e) / 64'(2 * k + 1);
                    end
                end
                prod = {64'd0, sum} * {64'd0, cau_pkg::DEG_Q32};
                atan_deg_q32[i] = prod[125:62];
            end
        end
    end

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic [31:0] clamp32(input logic signed [131:0] v);
        if (v > 132'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -132'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Angle in degrees (Q32) of a vector with positive parts, by CORDIC vectoring.
    function automatic logic [63:0] vector_angle(input logic [63:0] x0, input logic [63:0] y0);
        logic [63:0] x, y, xs, ys;
        longint      z;
        x = x0;
        y = y0;
        z = 0;
        while ((x > y ? x : y) >= (64'd1 << 61)) begin
            x = x >> 1;
            y = y >> 1;
        end
        while ((x > y ? x : y) < (64'd1 << 60)) begin
            x = x << 1;
            y = y << 1;
        end
        for (int i = 0; i < cau_pkg::CORDIC_ITERS; i++) begin
            xs = x >> i;
            ys = $signed(y) >>> i;
            if (!y[63]) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_deg_q32[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_deg_q32[i]);
            end
        end
        return z < 0 ? 64'd0 : 64'(z);
    endfunction

    // Expected result of one input item.
    function automatic t_result compute_result(input logic [135:0] d);
        cau_pkg::t_op         op;
        logic signed [131:0]  ar, ai, br, bi, nre, nim, den;
        logic [127:0]         sq;
        logic [63:0]          root, cand, ang;
        t_result              r;
        op  = cau_pkg::t_op'(d[2:0]);
        ar  = $signed(d[34:3]);
        ai  = $signed(d[66:35]);
        br  = $signed(d[98:67]);
        bi  = $signed(d[130:99]);
        r   = '0;
        case (op)
            cau_pkg::OP_ADD: begin
                r.re = clamp32(ar + br);
                r.im = clamp32(ai + bi);
            end
            cau_pkg::OP_SUB: begin
                r.re = clamp32(ar - br);
                r.im = clamp32(ai - bi);
            end
            cau_pkg::OP_MUL: begin
                r.re = clamp32((ar * br - ai * bi) / 132'sd65536);
                r.im = clamp32((ar * bi + ai * br) / 132'sd65536);
            end
            cau_pkg::OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.err = 1'b1;
                end else begin
                    nre = ar * br + ai * bi;
                    nim = ai * br - ar * bi;
                    nre = nre < 0 ? -(((-nre) <<< FRAC) / den) : ((nre <<< FRAC) / den);
                    nim = nim < 0 ? -(((-nim) <<< FRAC) / den) : ((nim <<< FRAC) / den);
                    r.re = clamp32(nre);
                    r.im = clamp32(nim);
                end
            end
            cau_pkg::OP_MAG: begin
                sq   = 128'(ar * ar + ai * ai);
                root = '0;
                for (int b = 63; b >= 0; b--) begin
                    cand = root | (64'd1 << b);
                    if ({64'd0, cand} * {64'd0, cand} <= sq) root = cand;
                end
                r.re = clamp32($signed({68'd0, root}));
            end
            cau_pkg::OP_ARG: begin
                if (ar == 0 && ai == 0) begin
                    r.err = 1'b1;
                end else if (ar == 0) begin
                    r.re = ai < 0 ? -(32'd90 << FRAC) : (32'd90 << FRAC);
                end else if (ai != 0) begin
                    ang = vector_angle(64'(ar < 0 ? -ar : ar), 64'(ai < 0 ? -ai : ai));
                    ang = (ang + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
                    r.re = ((ar < 0) != (ai < 0)) ? -ang[31:0] : ang[31:0];
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    assign o_pending = expected_q.size();

    // Record expectations on input accepts and compare every output accept.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(compute_result(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h err %b", i_m_tdata, i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.re !== i_m_tdata[31:0] || want.im !== i_m_tdata[63:32] ||
                        want.err !== i_m_tuser) begin
                        if (o_errors < 10) begin
                            $display("mismatch: expected re %h im %h err %b, got re %h im %h err %b",
                                     want.re, want.im, want.err,
                                     i_m_tdata[31:0], i_m_tdata[63:32], i_m_tuser);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/complex_arith_unit_tb.sv =====
`timescale 1ns / 1ps

module complex_arith_unit_tb;

    localparam int STALL_LIMIT = 5000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    int           errors;
    int           pending;
    int           quiet_cycles;
    logic         stalls_on;

    complex_arith_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    complex_arith_unit_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The result side stalls at random unless stalls are switched off.
    always @(posedge i_clk) begin
        m_tready <= !(stalls_on && $urandom_range(99) < 10);
    end

    // Give up when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[complex_arith_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Operand drawn from extremes, small values or the full range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4, 5, 6: return 32'($signed($urandom_range(2097151)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until it is accepted.
    task automatic send_item(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        if (stalls_on && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, bi, br, ai, ar, op};
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
    endtask

    initial begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        i_rst_n      = 1'b0;
        stalls_on    = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: extremes, every operation and the special cases.
        send_item(cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(cau_pkg::OP_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000);
        send_item(cau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(cau_pkg::OP_MUL, 32'h0003_0000, 32'hFFFE_8000, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(cau_pkg::OP_DIV, 32'h0005_0000, 32'h0001_0000, 32'd0, 32'd0);
        send_item(cau_pkg::OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_item(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0);
        send_item(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(cau_pkg::OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_item(cau_pkg::OP_MAG, 32'd0, 32'd0, 32'h1234_5678, 32'd9);
        send_item(cau_pkg::OP_MAG, 32'h0003_0000, 32'hFFFC_0000, 32'd0, 32'd0);
        send_item(cau_pkg::OP_ARG, 32'd0, 32'd0, 32'd5, 32'd5);
        send_item(cau_pkg::OP_ARG, 32'd0, 32'h0000_0001, 32'd0, 32'd0);
        send_item(cau_pkg::OP_ARG, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_item(cau_pkg::OP_ARG, 32'hFFFF_0000, 32'd0, 32'd0, 32'd0);
        send_item(cau_pkg::OP_ARG, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
        send_item(cau_pkg::OP_ARG, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_item(cau_pkg::OP_ARG, 32'd1, 32'h8000_0000, 32'd0, 32'd0);
        send_item(3'd6, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random items, with a long stretch in the middle free of stalls.
        for (int n = 0; n < 750; n++) begin
            stalls_on <= !(n >= 250 && n < 450);
            send_item($urandom_range(99) < 96 ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6)),
                      pick_operand(), pick_operand(), pick_operand(), pick_operand());
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[complex_arith_unit] OK");
        end else begin
            $display("[complex_arith_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== complex_arith_unit.f =====
src/cau_pkg.sv
src/cau_csub.sv
src/cau_cordic_step.sv
src/complex_arith_unit.sv
tb/complex_arith_unit_checker.sv
tb/complex_arith_unit_tb.sv
